// File: rtl/frds_pkg.sv
// Shared types and constants for the recent distinct identifier set.
// Used by frds_cell, frds_chain and fifo_recent_distinct_set; no dependencies.
package frds_pkg;

  localparam int unsigned MaxEntriesDef = 32;
  localparam int unsigned IdentBitsDef  = 32;

  localparam int unsigned IdentOutW = 32;
  localparam int unsigned CountOutW = 6;
  localparam int unsigned CapW      = 6;
  localparam int unsigned TDataInW  = 32;
  localparam int unsigned TDataOutW = 80;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [CapW-1:0] CapacityReset = 6'd32;

  // Register index taken from paddr word address
  localparam logic RegCapacity = 1'b0;

  // Request kinds carried in tuser
  localparam logic ReqMessage = 1'b0;
  localparam logic ReqDump    = 1'b1;

  // Per-cycle command to every cell of the row
  typedef struct packed {
    logic shift;   // move toward older slots, new identifier enters cell 0
    logic rotate;  // move toward cell 0, head wraps to the tail cell
  } cell_ctrl_t;

  typedef struct packed {
    logic                 last;
    logic [CountOutW-1:0] stored_count;
    logic [IdentOutW-1:0] entry_ident;
    logic                 entry_valid;
    logic [IdentOutW-1:0] evicted_ident;
    logic                 evicted_valid;
    logic                 hit;
  } result_t;

endpackage

// File: rtl/frds_cell.sv
// One slot of the identifier row: holds an identifier, compares it with the key.
// Depends on frds_pkg.
module frds_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IDENT_BITS = frds_pkg::IdentBitsDef,
  parameter int unsigned CNT_W      = 6
) (
  input  logic                   clk_i,
  input  frds_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]       occupancy_i,
  input  logic [IDENT_BITS-1:0]  key_i,
  input  logic [IDENT_BITS-1:0]  left_i,
  input  logic [IDENT_BITS-1:0]  right_i,
  input  logic [IDENT_BITS-1:0]  head_i,
  output logic [IDENT_BITS-1:0]  ident_o,
  output logic                   match_o,
  output logic                   tail_o
);

  logic [IDENT_BITS-1:0] ident_q, ident_d;
  logic                  live;

  always_comb begin
    live    = CNT_W'(IDX) < occupancy_i;
    tail_o  = live && (CNT_W'(IDX + 1) == occupancy_i);
    match_o = live && (ident_q == key_i);
    ident_o = ident_q;
  end

  always_comb begin
    ident_d = ident_q;
    if (ctrl_i.shift) begin
      ident_d = left_i;
    end else if (ctrl_i.rotate) begin
      ident_d = tail_o ? head_i : right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ident_q <= ident_d;
  end

endmodule

// File: rtl/frds_chain.sv
// Row of frds_cell slots, newest at cell 0; gathers hit and oldest identifier.
// Depends on frds_pkg and frds_cell.
module frds_chain #(
  parameter int unsigned MAX_ENTRIES = frds_pkg::MaxEntriesDef,
  parameter int unsigned IDENT_BITS  = frds_pkg::IdentBitsDef,
  parameter int unsigned CNT_W       = 6
) (
  input  logic                   clk_i,
  input  frds_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]       occupancy_i,
  input  logic [IDENT_BITS-1:0]  key_i,
  output logic                   hit_o,
  output logic [IDENT_BITS-1:0]  oldest_o,
  output logic [IDENT_BITS-1:0]  head_o
);

  logic [IDENT_BITS-1:0] ident [MAX_ENTRIES];
  logic [IDENT_BITS-1:0] left  [MAX_ENTRIES];
  logic [IDENT_BITS-1:0] right [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] tail;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = key_i;
    end else begin : g_inner
      assign left[i] = ident[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_end
      assign right[i] = '0;
    end else begin : g_mid
      assign right[i] = ident[i+1];
    end

    frds_cell #(
      .IDX        (i),
      .IDENT_BITS (IDENT_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .occupancy_i (occupancy_i),
      .key_i       (key_i),
      .left_i      (left[i]),
      .right_i     (right[i]),
      .head_i      (ident[0]),
      .ident_o     (ident[i]),
      .match_o     (match[i]),
      .tail_o      (tail[i])
    );
  end

  always_comb begin
    hit_o    = |match;
    head_o   = ident[0];
    oldest_o = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      oldest_o = oldest_o | (ident[i] & {IDENT_BITS{tail[i]}});
    end
  end

endmodule

// File: rtl/fifo_recent_distinct_set.sv
// Recent distinct identifier set: one request per cycle is accepted while no dump is
// in progress and the output register is free; a message's result is valid the cycle after.
// A dump of n stored entries emits one result per cycle while the output is taken;
// its first result passes through the dump state and then the output register. An
// empty set answers in one result like a message. Reset clears occupancy, the state
// machine and the output valid, sets capacity to 32, and leaves stored identifiers as they are.
module fifo_recent_distinct_set #(
  parameter int unsigned MAX_ENTRIES = frds_pkg::MaxEntriesDef,
  parameter int unsigned IDENT_BITS  = frds_pkg::IdentBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [frds_pkg::TDataInW-1:0]    s_axis_tdata,  // [31:0] ident
  input  logic                             s_axis_tuser,  // [0] req_type
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] hit, [1] evicted_valid, [33:2] evicted_ident, [34] entry_valid,
  // [66:35] entry_ident, [72:67] stored_count, [79:73] zero
  output logic [frds_pkg::TDataOutW-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,
  // Register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [frds_pkg::ApbAddrW-1:0]    paddr,
  input  logic [frds_pkg::ApbDataW-1:0]    pwdata,
  output logic [frds_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > frds_pkg::CapW) ? CNT_W : frds_pkg::CapW;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e                      state_q;
  logic [CNT_W-1:0]            occ_q, occ_d;
  logic [CNT_W-1:0]            remain_q;
  logic [frds_pkg::CapW-1:0]   cap_q;
  logic                        out_valid_q;
  frds_pkg::result_t           out_q, out_d;

  frds_pkg::cell_ctrl_t        ctrl;
  logic [IDENT_BITS-1:0]       key;
  logic                        hit;
  logic [IDENT_BITS-1:0]       oldest;
  logic [IDENT_BITS-1:0]       head;

  logic                        out_free;
  logic                        req_acc;
  logic                        is_msg;
  logic                        full;
  logic                        evict;
  logic                        emit;
  logic [CMP_W-1:0]            occ_w, cap_w, eff_cap;
  logic [CMP_W-1:0]            occ_d_w;

  // ---------------------------------------------------------------------------
  // Register port: a single capacity register, decoded by word address
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      frds_pkg::RegCapacity: prdata = frds_pkg::ApbDataW'(cap_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= frds_pkg::CapacityReset;
    end else if (psel && penable && pwrite && (paddr[2] == frds_pkg::RegCapacity)) begin
      cap_q <= pwdata[frds_pkg::CapW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Request side: accept only from idle, and only when the result can be held
  // ---------------------------------------------------------------------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign is_msg        = (s_axis_tuser == frds_pkg::ReqMessage);
  assign key           = IDENT_BITS'(s_axis_tdata);

  // Effective capacity: zero acts as one, anything above the depth as the depth
  always_comb begin
    occ_w = CMP_W'(occ_q);
    cap_w = CMP_W'(cap_q);
    if (cap_w == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_w > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_w;
    end
    full  = occ_w >= eff_cap;
    evict = !hit && full;
  end

  // Dump emits the head cell and rotates the row by one each cycle the output is free
  assign emit = (state_q == ST_DUMP) && out_free;

  always_comb begin
    ctrl.shift  = req_acc && is_msg && !hit;
    ctrl.rotate = emit;
  end

  frds_chain #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDENT_BITS  (IDENT_BITS),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .occupancy_i (occ_q),
    .key_i       (key),
    .hit_o       (hit),
    .oldest_o    (oldest),
    .head_o      (head)
  );

  // Next occupancy: a miss grows the set unless the oldest entry drops out
  always_comb begin
    occ_d = occ_q;
    if (req_acc && is_msg && !hit && !evict) begin
      occ_d = occ_q + CNT_W'(1);
    end
    occ_d_w = CMP_W'(occ_d);
  end

  // Result for the cycle's request or dump step
  always_comb begin
    out_d = '0;
    out_d.stored_count = occ_d_w[frds_pkg::CountOutW-1:0];
    out_d.last         = 1'b1;
    if (emit) begin
      out_d.entry_valid = 1'b1;
      out_d.entry_ident = frds_pkg::IdentOutW'(head);
      out_d.last        = (remain_q == CNT_W'(1));
    end else if (is_msg) begin
      out_d.hit           = hit;
      out_d.evicted_valid = evict;
      out_d.evicted_ident = evict ? frds_pkg::IdentOutW'(oldest) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, occupancy and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            // A dump of a non-empty set walks the row; an empty one answers now
            if (!is_msg && (occ_q != '0)) begin
              out_valid_q <= 1'b0;
              remain_q    <= occ_q;
              state_q     <= ST_DUMP;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (out_free) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_DUMP: begin
          // Emit fires exactly when the previous result is gone
          if (emit) begin
            out_valid_q <= 1'b1;
            remain_q    <= remain_q - CNT_W'(1);
            if (remain_q == CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk_i) begin
    if ((req_acc && (is_msg || (occ_q == '0))) || emit) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'b0, out_q.stored_count, out_q.entry_ident, out_q.entry_valid,
                          out_q.evicted_ident, out_q.evicted_valid, out_q.hit};

endmodule
